@@ design/multi_client_watchdog_table_top_macros.svh @@
// Assertion macros for the watchdog table modules.
// Uses the aclk / aresetn port names of the including module.
`ifndef MULTI_CLIENT_WATCHDOG_TABLE_TOP_MACROS_SVH
`define MULTI_CLIENT_WATCHDOG_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define MCWT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// checked on every edge, reset included
`define MCWT_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);
`else
`define MCWT_ASSERT(label, prop, msg)
`define MCWT_ASSERT_ANY(label, prop, msg)
`endif

`endif

@@ design/mcwt_pkg.sv @@
// Shared types and constants for the watchdog table.
// No dependencies.
package mcwt_pkg;

    localparam int KEY_W    = 32;
    localparam int CALLER_W = 31;
    localparam int STAT_W   = 2;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_KICK   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2
    } op_t;

    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd0;
    localparam logic [STAT_W-1:0] ST_ACTIVE  = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] specific_id;
        logic [CALLER_W-1:0]     caller_id;
        logic [STAT_W-1:0]       kick_status;
    } in_item_t;

    typedef struct packed {
        logic                    happy;
        logic signed [KEY_W-1:0] failing_key;
        logic                    table_full;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    // negated specific id, or caller id when the specific id is zero
    function automatic logic [KEY_W-1:0] client_key(input logic [KEY_W-1:0] spec,
                                                    input logic [CALLER_W-1:0] caller);
        logic [KEY_W-1:0] res;
        if (spec == '0) begin
            res = {1'b0, caller};
        end else begin
            res = ~spec + {{(KEY_W-1){1'b0}}, 1'b1};
        end
        return res;
    endfunction

endpackage

@@ design/mcwt_ctrl.sv @@
// Sequencing state machine of the watchdog table.
// Depends on mcwt_pkg and the assertion macro header.
`include "multi_client_watchdog_table_top_macros.svh"

module mcwt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mcwt_pkg::dp_stat_t   st,
    output mcwt_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (st.scan_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // wait for the result register to drain
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `MCWT_ASSERT(a_accept_starts_scan, (s_valid && s_ready) |=> (state_reg == S_SCAN), "accepted item did not start a scan")
    `MCWT_ASSERT(a_out_load_when_free, cmd.out_load |-> st.out_free, "result loaded over a pending result")
    `MCWT_ASSERT(a_done_only_in_scan, st.scan_done |-> (state_reg == S_SCAN), "scan done outside scan state")
    `MCWT_ASSERT_ANY(a_reset_to_idle, !aresetn |=> (state_reg == S_IDLE), "reset did not return to idle")

endmodule

@@ design/mcwt_datapath.sv @@
// Slot storage, scan pipeline and result register of the watchdog table.
// Depends on mcwt_pkg and the assertion macro header.
`include "multi_client_watchdog_table_top_macros.svh"

module mcwt_datapath #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mcwt_pkg::ctrl_cmd_t  cmd,
    output mcwt_pkg::dp_stat_t   st,
    input  mcwt_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mcwt_pkg::out_item_t  m_data
);

    localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_CLIENTS - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(MAX_CLIENTS);
    localparam int KW = mcwt_pkg::KEY_W;
    localparam int SW = mcwt_pkg::STAT_W;

    // slot memories: entries are read only behind a set valid bit
    logic [KW-1:0] key_mem  [MAX_CLIENTS];
    logic [SW-1:0] stat_mem [MAX_CLIENTS];

    logic [MAX_CLIENTS-1:0]    valid_reg, valid_next;
    logic [mcwt_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]             key_reg;
    logic [SW-1:0]             kst_reg;
    logic [CW-1:0]             rd_cnt_reg;
    logic                      cmp_live_reg;
    logic [IW-1:0]             cmp_idx_reg;
    logic [KW-1:0]             key_rd_reg;
    logic [SW-1:0]             stat_rd_reg;
    logic                      hit_reg;
    logic [IW-1:0]             hit_idx_reg;
    logic                      free_found_reg;
    logic [IW-1:0]             free_idx_reg;
    logic                      happy_reg;
    logic [KW-1:0]             fkey_reg;
    logic                      full_reg;
    logic                      m_valid_reg;
    mcwt_pkg::out_item_t       m_data_reg;

    logic          cmp_valid, key_match, is_last, step, found;
    logic          stat_we, key_we;
    logic [IW-1:0] wr_idx;
    logic [SW-1:0] wr_stat;
    logic          kick_full;

    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign key_match = cmp_valid && (key_rd_reg == key_reg);
    assign is_last   = (cmp_idx_reg == LAST_IDX);
    assign step      = cmd.scan && cmp_live_reg;

    always_comb begin
        case (op_reg)
            mcwt_pkg::OP_KICK:   found = key_match;
            mcwt_pkg::OP_REMOVE: found = key_match;
            mcwt_pkg::OP_CHECK:  found = cmp_valid && (stat_rd_reg == mcwt_pkg::ST_UNKNOWN);
            default:             found = 1'b1;  // unused code: stop at once
        endcase
    end

    assign st.scan_done = step && (found || is_last);
    assign st.out_free  = !m_valid_reg || m_ready;

    assign kick_full = cmd.commit && (op_reg == mcwt_pkg::OP_KICK)
                       && !hit_reg && !free_found_reg;

    // single write port shared by check demotion and kick commit
    always_comb begin
        stat_we    = 1'b0;
        key_we     = 1'b0;
        wr_idx     = cmp_idx_reg;
        wr_stat    = mcwt_pkg::ST_UNKNOWN;
        valid_next = valid_reg;
        if (step && (op_reg == mcwt_pkg::OP_CHECK) && cmp_valid
            && (stat_rd_reg == mcwt_pkg::ST_ACTIVE)) begin
            stat_we = 1'b1;
        end
        if (step && (op_reg == mcwt_pkg::OP_REMOVE) && key_match) begin
            valid_next[cmp_idx_reg] = 1'b0;
        end
        if (cmd.commit && (op_reg == mcwt_pkg::OP_KICK)) begin
            wr_stat = kst_reg;
            if (hit_reg) begin
                stat_we = 1'b1;
                wr_idx  = hit_idx_reg;
            end else if (free_found_reg) begin
                stat_we = 1'b1;
                key_we  = 1'b1;
                wr_idx  = free_idx_reg;
                valid_next[free_idx_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stat_we) begin
            stat_mem[wr_idx] <= wr_stat;
        end
        if (key_we) begin
            key_mem[wr_idx] <= key_reg;
        end
        key_rd_reg  <= key_mem[rd_cnt_reg[IW-1:0]];
        stat_rd_reg <= stat_mem[rd_cnt_reg[IW-1:0]];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            cmp_live_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.load) begin
                cmp_live_reg <= 1'b0;
            end else if (cmd.scan) begin
                cmp_live_reg <= (rd_cnt_reg != CNT_END);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_data.operation;
            key_reg        <= mcwt_pkg::client_key(s_data.specific_id, s_data.caller_id);
            kst_reg        <= s_data.kick_status;
            rd_cnt_reg     <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            happy_reg      <= 1'b1;
            fkey_reg       <= '0;
            full_reg       <= 1'b0;
        end else begin
            if (cmd.scan && (rd_cnt_reg != CNT_END)) begin
                rd_cnt_reg  <= rd_cnt_reg + 1'b1;
                cmp_idx_reg <= rd_cnt_reg[IW-1:0];
            end
            if (step && (op_reg == mcwt_pkg::OP_KICK) && key_match) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
            if (step && !cmp_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
            if (step && (op_reg == mcwt_pkg::OP_CHECK) && found) begin
                happy_reg <= 1'b0;
                fkey_reg  <= key_rd_reg;
            end
            if (kick_full) begin
                full_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            m_data_reg.happy       <= happy_reg;
            m_data_reg.failing_key <= fkey_reg;
            m_data_reg.table_full  <= full_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MCWT_ASSERT(a_full_only_if_all_used, kick_full |-> (&valid_reg), "table full flagged with a free slot")
    `MCWT_ASSERT(a_unhappy_only_check, (cmd.out_load && !happy_reg) |-> (op_reg == mcwt_pkg::OP_CHECK), "unhappy result from a non-check item")
    `MCWT_ASSERT(a_hit_slot_valid, (cmd.commit && hit_reg) |-> valid_reg[hit_idx_reg], "kick hit on an empty slot")

endmodule

@@ design/multi_client_watchdog_table_top.sv @@
// Watchdog table of MAX_CLIENTS watched clients (signed key plus 2-bit status),
// built from mcwt_pkg, mcwt_ctrl and mcwt_datapath. Items are handled one at a
// time: kick, remove or check walks the slots in index order, one slot per
// cycle through the registered read of the slot memory, stopping at the first
// match (for check: a valid slot in unknown status) or the last slot; then it
// commits and loads its result once the output register is free. A new item is
// accepted while the previous result still waits in the output register. Kick of
// a new client takes the lowest free slot, or sets table_full if none is free.
module multi_client_watchdog_table_top #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mcwt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mcwt_pkg::out_item_t m_data
);

    mcwt_pkg::ctrl_cmd_t cmd;
    mcwt_pkg::dp_stat_t  st;

    mcwt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mcwt_datapath #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .st      (st),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
